/* design/wip_pkg.sv */
// Shared constants and types for the windowed instantaneous period core.
// No dependencies; imported by the interfaces and the core.
`default_nettype none
package wip_pkg;
    localparam int WINDOW_MAX_DEF  = 1024;
    localparam int SAMPLE_BITS_DEF = 24;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 29;
    localparam int WL_FIELD_W  = 11;
    localparam int SP_W        = 29;
    localparam int PERIOD_W    = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_LENGTH = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 1'd1;

    localparam int              WL_RESET   = 100;
    localparam logic [SP_W-1:0] SP_RESET   = 29'd167772;
    // 2*pi with 29 fraction bits
    localparam logic [31:0]     TWO_PI_Q29 = 32'd3373259426;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_SQ0  = 13'b0000000000010,
        S_SQ1  = 13'b0000000000100,
        S_SQ2  = 13'b0000000001000,
        S_SQ3  = 13'b0000000010000,
        S_SQ4  = 13'b0000000100000,
        S_CHK  = 13'b0000001000000,
        S_DIV  = 13'b0000010000000,
        S_SQRT = 13'b0000100000000,
        S_M0   = 13'b0001000000000,
        S_M1   = 13'b0010000000000,
        S_M2   = 13'b0100000000000,
        S_OUT  = 13'b1000000000000
    } t_state;
endpackage
`default_nettype wire

/* design/wip_ifs.sv */
// Valid/ready channel interfaces for sample, period and configuration beats.
// Depends on wip_pkg for field widths.
`default_nettype none
interface wip_sample_if
    import wip_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_value;
    modport source (output valid, output sample_value, input ready);
    modport sink   (input valid, input sample_value, output ready);
endinterface

interface wip_period_if
    import wip_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period_value;
    logic                no_energy;
    modport source (output valid, output period_value, output no_energy, input ready);
    modport sink   (input valid, input period_value, input no_energy, output ready);
endinterface

interface wip_cfg_if
    import wip_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/windowed_instant_period_core.sv */
// Windowed instantaneous period core: sample rings, window energy sums and
// a sequencer around one shared multiplier and one shared subtractor.
// Depends on wip_pkg and the channel interfaces in wip_ifs.sv.
//
//  channel   dir  beat
//  i_sample  in   sample_value (signed)
//  o_period  out  period_value, no_energy
//  i_cfg     in   index, data (register write, always ready)
//
// A sample is accepted only in the idle state; the next is taken once its result
// is registered for o_period. The bit-serial divider runs one quotient bit a cycle
// and stops early when the quotient saturates, then the square root runs, both
// on the shared subtractor. Zero difference energy skips both: the result goes
// straight from the energy check to the output step.
// After reset and after each window_length write the rings are zeroed one
// entry a cycle, all WINDOW_MAX of them, and no sample is taken meanwhile.
// A result waiting on o_period holds the sequencer only at its final step.
`default_nettype none
module windowed_instant_period_core
    import wip_pkg::*;
#(
    parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    wip_sample_if.sink        i_sample,
    wip_period_if.source      o_period,
    wip_cfg_if.sink           i_cfg
);
    localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int WL_W    = $clog2(WINDOW_MAX + 1);
    localparam int DIFF_W  = SAMPLE_BITS + 1;
    localparam int XW      = 2 * SAMPLE_BITS - 1 + $clog2(WINDOW_MAX);
    localparam int DW      = XW + 2;
    localparam int MUL_W   = (DIFF_W > 32) ? DIFF_W : 32;
    localparam int SUB_W   = (DW + 1 > 64) ? DW + 1 : 64;
    localparam int CNT_W   = $clog2(XW + 32);
    localparam int WL_INIT = (WL_RESET > WINDOW_MAX) ? WINDOW_MAX : WL_RESET;

    logic signed [SAMPLE_BITS-1:0] ring_x [WINDOW_MAX];
    logic signed [DIFF_W-1:0]      ring_d [WINDOW_MAX];

    t_state                        r_state;
    logic                          r_clr;
    logic [PTR_W-1:0]              r_clr_addr;
    logic [WL_W-1:0]               r_wl;
    logic [SP_W-1:0]               r_sp;
    logic [PTR_W-1:0]              r_ptr;
    logic signed [SAMPLE_BITS-1:0] r_prev;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic signed [DIFF_W-1:0]      r_d;
    logic signed [SAMPLE_BITS-1:0] r_old_x;
    logic signed [DIFF_W-1:0]      r_old_d;
    logic [XW-1:0]                 r_sum_x;
    logic [DW-1:0]                 r_sum_d;
    logic [2*MUL_W-1:0]            r_prod;
    logic [DW-1:0]                 r_rem;
    logic [XW-1:0]                 r_dvd;
    logic [CNT_W-1:0]              r_cnt;
    logic [63:0]                   r_q;
    logic [63:0]                   r_res;
    logic [63:0]                   r_bit;
    logic [31:0]                   r_a_lo;
    logic [63:0]                   r_hi;
    logic                          r_ov;
    logic [PERIOD_W-1:0]           r_pv;
    logic                          r_ne;
    logic [PERIOD_W-1:0]           r_res_pv;
    logic                          r_res_ne;

    logic               in_beat;
    logic               cfg_beat;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [SUB_W-1:0]   sub_a;
    logic [SUB_W-1:0]   sub_b;
    logic [SUB_W:0]     sub_diff;
    logic               sub_ge;
    logic signed [DIFF_W-1:0] in_d;
    logic [SAMPLE_BITS-1:0]   mag_old_x;
    logic [DIFF_W-1:0]        mag_old_d;
    logic [SAMPLE_BITS-1:0]   mag_x;
    logic [DIFF_W-1:0]        mag_d;
    logic [DW:0]              div_rs;
    logic [PTR_W:0]           ptr_inc;
    logic [WL_FIELD_W-1:0]    wl_field;
    logic [WL_W-1:0]          wl_clamped;
    logic [63:0]              scale_t;
    logic [42:0]              scale_p;
    logic                     out_free;

    assign in_beat  = i_sample.valid && i_sample.ready;
    assign cfg_beat = i_cfg.valid && i_cfg.ready;
    assign i_sample.ready = (r_state == S_IDLE) && !r_clr;
    assign i_cfg.ready    = 1'b1;
    assign o_period.valid        = r_ov;
    assign o_period.period_value = r_pv;
    assign o_period.no_energy    = r_ne;
    assign out_free = !r_ov || o_period.ready;

    assign in_d = DIFF_W'(i_sample.sample_value) - DIFF_W'(r_prev);

    assign mag_old_x = r_old_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_old_x) : r_old_x;
    assign mag_old_d = r_old_d[DIFF_W-1] ? DIFF_W'(-r_old_d) : r_old_d;
    assign mag_x     = r_x[SAMPLE_BITS-1] ? SAMPLE_BITS'(-r_x) : r_x;
    assign mag_d     = r_d[DIFF_W-1] ? DIFF_W'(-r_d) : r_d;

    assign div_rs   = {r_rem, r_dvd[XW-1]};
    assign ptr_inc  = {1'b0, r_ptr} + 1'b1;

    assign wl_field = i_cfg.data[WL_FIELD_W-1:0];
    always_comb begin
        if (wl_field == '0) begin
            wl_clamped = WL_W'(1);
        end else if (32'(wl_field) > 32'(WINDOW_MAX)) begin
            wl_clamped = WL_W'(WINDOW_MAX);
        end else begin
            wl_clamped = WL_W'(wl_field);
        end
    end

    // shared multiplier operands
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SQ0: begin
                mul_a = MUL_W'(mag_old_x);
                mul_b = MUL_W'(mag_old_x);
            end
            S_SQ1: begin
                mul_a = MUL_W'(mag_old_d);
                mul_b = MUL_W'(mag_old_d);
            end
            S_SQ2: begin
                mul_a = MUL_W'(mag_x);
                mul_b = MUL_W'(mag_x);
            end
            S_SQ3: begin
                mul_a = MUL_W'(mag_d);
                mul_b = MUL_W'(mag_d);
            end
            S_M0: begin
                mul_a = MUL_W'(r_sp);
                mul_b = MUL_W'(r_res[31:0]);
            end
            S_M1: begin
                mul_a = MUL_W'(r_prod[63:32]);
                mul_b = MUL_W'(TWO_PI_Q29);
            end
            S_M2: begin
                mul_a = MUL_W'(r_a_lo);
                mul_b = MUL_W'(TWO_PI_Q29);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared subtractor: divider remainder step or square-root step
    always_comb begin
        if (r_state == S_DIV) begin
            sub_a = SUB_W'(div_rs);
            sub_b = SUB_W'(r_sum_d);
        end else begin
            sub_a = SUB_W'(r_q);
            sub_b = SUB_W'(r_res | r_bit);
        end
        sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
        sub_ge   = !sub_diff[SUB_W];
    end

    assign scale_t = r_hi + 64'(r_prod[63:32]);
    assign scale_p = scale_t[63:21];

    // ring memories: clear sweep or one write per sample, registered read
    always_ff @(posedge i_clk) begin
        if (r_clr) begin
            ring_x[r_clr_addr] <= '0;
            ring_d[r_clr_addr] <= '0;
        end else if (r_state == S_SQ0) begin
            ring_x[r_ptr] <= r_x;
            ring_d[r_ptr] <= r_d;
        end
        if (in_beat) begin
            r_old_x <= ring_x[r_ptr];
            r_old_d <= ring_d[r_ptr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_wl       <= WL_W'(WL_INIT);
            r_sp       <= SP_RESET;
            r_ptr      <= '0;
            r_prev     <= '0;
            r_sum_x    <= '0;
            r_sum_d    <= '0;
            r_ov       <= 1'b0;
        end else begin
            if (r_ov && o_period.ready) begin
                r_ov <= 1'b0;
            end
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (32'(r_clr_addr) == WINDOW_MAX - 1) begin
                    r_clr <= 1'b0;
                end
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_x     <= i_sample.sample_value;
                        r_d     <= in_d;
                        r_prev  <= i_sample.sample_value;
                        r_state <= S_SQ0;
                    end
                end
                S_SQ0: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_sum_x <= r_sum_x - XW'(r_prod);
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_sum_d <= r_sum_d - DW'(r_prod);
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_SQ3;
                end
                S_SQ3: begin
                    r_sum_x <= r_sum_x + XW'(r_prod);
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_SQ4;
                end
                S_SQ4: begin
                    r_sum_d <= r_sum_d + DW'(r_prod);
                    // wrap at the window end
                    if (32'(ptr_inc) >= 32'(r_wl)) begin
                        r_ptr <= '0;
                    end else begin
                        r_ptr <= PTR_W'(ptr_inc);
                    end
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_sum_d == '0) begin
                        r_res_pv <= '0;
                        r_res_ne <= 1'b1;
                        r_state  <= S_OUT;
                    end else begin
                        r_rem   <= '0;
                        r_dvd   <= r_sum_x;
                        r_q     <= '0;
                        r_cnt   <= CNT_W'(XW + 31);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_dvd <= r_dvd << 1;
                    r_cnt <= r_cnt - 1'b1;
                    r_rem <= sub_ge ? DW'(sub_diff) : DW'(div_rs);
                    r_q   <= {r_q[62:0], sub_ge};
                    if (sub_ge && (32'(r_cnt) >= 32'd64)) begin
                        // quotient overflows 64 bits: saturate
                        r_q     <= '1;
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end else if (r_cnt == '0) begin
                        r_res   <= '0;
                        r_bit   <= 64'd1 << 62;
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (sub_ge) begin
                        r_q   <= 64'(sub_diff);
                        r_res <= (r_res >> 1) | r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= S_M0;
                    end
                end
                S_M0: begin
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_a_lo  <= r_prod[31:0];
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_hi    <= r_prod[63:0];
                    r_prod  <= mul_a * mul_b;
                    r_state <= S_OUT;
                    r_res_ne <= 1'b0;
                end
                S_OUT: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_ne    <= r_res_ne;
                        if (r_res_ne) begin
                            r_pv <= r_res_pv;
                        end else if (scale_p[42:32] != '0) begin
                            r_pv <= '1;
                        end else begin
                            r_pv <= scale_p[31:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (cfg_beat) begin
                unique case (i_cfg.index)
                    REG_WINDOW_LENGTH: begin
                        r_wl       <= wl_clamped;
                        r_clr      <= 1'b1;
                        r_clr_addr <= '0;
                        r_ptr      <= '0;
                        r_prev     <= '0;
                        r_sum_x    <= '0;
                        r_sum_d    <= '0;
                    end
                    REG_SAMPLE_PERIOD: begin
                        r_sp <= i_cfg.data[SP_W-1:0];
                    end
                    default: begin
                        r_sp <= r_sp;
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire
